// File: rtl/rgbsharp_pkg.sv
// Shared types and constants for the RGB 3x3 sharpen block.
// No dependencies; imported by the window, kernel and top-level modules.
`default_nettype none

package rgbsharp_pkg;

   // One RGB pixel, red in the upper byte.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // The five neighbors that the kernel needs for one output pixel.
   typedef struct packed {
      pixel_type left;
      pixel_type up;
      pixel_type center;
      pixel_type down;
      pixel_type right;
   } taps_type;

   // Register map, index = paddr[3:2]
   typedef enum logic [1:0] {
      REG_AMOUNT,
      REG_WIDTH,
      REG_HEIGHT
   } reg_index_type;

   localparam logic [6:0]  AMOUNT_RESET = 7'd100;
   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [12:0] HEIGHT_RESET = 13'd480;

   localparam logic [6:0]  PASS_AMOUNT  = 7'd50;   // unity gain
   localparam logic [6:0]  MAX_AMOUNT   = 7'd100;  // above this: pass-through
   localparam logic [7:0]  AMOUNT_BIAS  = 8'd15;

   // q = p / 100 as (p * 5243) >> 19, exact for 0 <= p < 43690
   localparam logic [12:0] RECIP_100    = 13'd5243;
   localparam int          RECIP_SHIFT  = 19;
   localparam int          CLAMP_LIMIT  = 25600;   // 256 * 100
   localparam logic [7:0]  PIXEL_MAX    = 8'd255;

   localparam int          MIN_DIM      = 3;

   // Clamp a programmed dimension to MIN_DIM..maxv
   function automatic int limit_dim(logic [31:0] v, int maxv);
      int res;
      res = int'(v);
      if (v < 32'(MIN_DIM)) begin
         res = MIN_DIM;
      end else if (v > 32'(maxv)) begin
         res = maxv;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/rgb_sharpen_3x3_convolution.sv
// RGB 3x3 sharpen filter on a raster pixel stream.
//
// Input beats (req_*) carry one pixel each in raster order; req_frame_start
// marks row 0, column 0 and restarts the position counters, which also wrap
// by themselves after the last pixel of an image. For every interior pixel
// a result beat (rsp_*) carries the sharpened pixel with its column and row;
// border pixels produce no beat. rsp_last_of_frame flags pixel
// (height-2, width-2). Strength, width and height sit in an APB register
// file (amount at 0x0, image_width at 0x4, image_height at 0x8). The user
// must change them only while the stream is idle, unenforced by the block.
//
// Throughput: one pixel per clock while the output is not stalled. Four
// register stages (line store read, Laplacian sum, gain multiply, reciprocal
// divide into the output register); a result waits for the pixel one row down
// and one column right. When rsp_ready is low the pipeline keeps taking beats
// until its empty stages fill, then drops req_ready; nothing is lost or
// repeated. Reset clears the counters, window and valid bits; line stores
// hold their contents and need no clearing.
// Depends on rgbsharp_pkg, rgbsharp_window, rgbsharp_kernel, rgbsharp_ram.
`default_nettype none

module rgb_sharpen_3x3_convolution
   import rgbsharp_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [3:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   // pixel input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_red_in,
   input  logic [7:0]                    req_green_in,
   input  logic [7:0]                    req_blue_in,
   input  logic                          req_frame_start,
   // sharpened output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_red_out,
   output logic [7:0]                    rsp_green_out,
   output logic [7:0]                    rsp_blue_out,
   output logic [$clog2(MAX_WIDTH)-1:0]  rsp_out_column,
   output logic [$clog2(MAX_HEIGHT)-1:0] rsp_out_row,
   output logic                          rsp_last_of_frame
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int WLW = $clog2(MAX_WIDTH + 1);
   localparam int HLW = $clog2(MAX_HEIGHT + 1);

   logic [6:0]     amount_ff;
   logic [11:0]    width_ff;
   logic [12:0]    height_ff;
   logic [WLW-1:0] w_lim_ff;
   logic [HLW-1:0] h_lim_ff;
   logic           csr_write;
   reg_index_type  csr_index;

   pixel_type      in_pixel;
   pixel_type      out_pixel;
   taps_type       taps;
   logic           tap_valid;
   logic           tap_ready;
   logic [CW-1:0]  tap_column;
   logic [RW-1:0]  tap_row;
   logic           tap_last;

   // register file; low address bits select byte lanes and are ignored
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = reg_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff <= AMOUNT_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_AMOUNT: amount_ff <= pwdata[6:0];
            REG_WIDTH:  width_ff  <= pwdata[11:0];
            REG_HEIGHT: height_ff <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_AMOUNT: prdata = 32'(amount_ff);
         REG_WIDTH:  prdata = 32'(width_ff);
         REG_HEIGHT: prdata = 32'(height_ff);
         default:    prdata = '0;
      endcase
   end

   // effective image size
   always_ff @(posedge clock) begin
      if (reset) begin
         w_lim_ff <= WLW'(limit_dim(32'(WIDTH_RESET), MAX_WIDTH));
         h_lim_ff <= HLW'(limit_dim(32'(HEIGHT_RESET), MAX_HEIGHT));
      end else begin
         w_lim_ff <= WLW'(limit_dim(32'(width_ff), MAX_WIDTH));
         h_lim_ff <= HLW'(limit_dim(32'(height_ff), MAX_HEIGHT));
      end
   end

   assign in_pixel.red   = req_red_in;
   assign in_pixel.green = req_green_in;
   assign in_pixel.blue  = req_blue_in;

   rgbsharp_window #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .w_lim          (w_lim_ff),
      .h_lim          (h_lim_ff),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_pixel       (in_pixel),
      .in_frame_start (req_frame_start),
      .tap_valid      (tap_valid),
      .tap_ready      (tap_ready),
      .taps           (taps),
      .tap_column     (tap_column),
      .tap_row        (tap_row),
      .tap_last       (tap_last)
   );

   rgbsharp_kernel #(
      .COL_W (CW),
      .ROW_W (RW)
   ) u_kernel (
      .clock      (clock),
      .reset      (reset),
      .amount     (amount_ff),
      .in_valid   (tap_valid),
      .in_ready   (tap_ready),
      .taps       (taps),
      .in_column  (tap_column),
      .in_row     (tap_row),
      .in_last    (tap_last),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_pixel  (out_pixel),
      .out_column (rsp_out_column),
      .out_row    (rsp_out_row),
      .out_last   (rsp_last_of_frame)
   );

   assign rsp_red_out   = out_pixel.red;
   assign rsp_green_out = out_pixel.green;
   assign rsp_blue_out  = out_pixel.blue;

endmodule

`default_nettype wire

// File: rtl/rgbsharp_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old data. No dependencies.
`default_nettype none

module rgbsharp_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rgbsharp_window.sv
// Raster position counters, two line stores and the 3x3 neighborhood window.
// Depends on rgbsharp_pkg and rgbsharp_ram.
`default_nettype none

module rgbsharp_window
   import rgbsharp_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]  w_lim,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0] h_lim,
   // incoming pixels
   input  logic                            in_valid,
   output logic                            in_ready,
   input  pixel_type                       in_pixel,
   input  logic                            in_frame_start,
   // neighborhoods of interior pixels
   output logic                            tap_valid,
   input  logic                            tap_ready,
   output taps_type                        taps,
   output logic [$clog2(MAX_WIDTH)-1:0]    tap_column,
   output logic [$clog2(MAX_HEIGHT)-1:0]   tap_row,
   output logic                            tap_last
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic          accept;
   logic          free1;
   logic          s1_leave;

   logic [CW-1:0] col_ff, col_in, col_cur;
   logic [RW-1:0] row_ff, row_in, row_cur;
   logic          emit_cur;
   logic          last_cur;

   // stage 1: line store data arrives
   logic          s1_v_ff;
   logic [CW-1:0] s1_col_ff;
   logic [RW-1:0] s1_row_ff;
   pixel_type     s1_px_ff;
   logic          s1_emit_ff;
   logic          s1_last_ff;
   logic          s1_byp_ff;
   pixel_type     byp_data_ff;

   pixel_type     top_rd;
   pixel_type     mid_rd;
   pixel_type     top_eff;

   // window: middle of column c-2, and column c-1
   pixel_type     left_ff, up_ff, cen_ff, down_ff;

   assign free1    = !s1_v_ff || !s1_emit_ff || tap_ready;
   assign in_ready = free1;
   assign accept   = in_valid && free1;
   assign s1_leave = s1_v_ff && free1;

   // position of the arriving pixel and the next position
   always_comb begin
      col_cur = col_ff;
      row_cur = row_ff;
      if (in_frame_start || 32'(col_ff) >= 32'(w_lim)) begin
         col_cur = '0;
      end
      if (in_frame_start || 32'(row_ff) >= 32'(h_lim)) begin
         row_cur = '0;
      end
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (32'(col_cur) + 32'd1 >= 32'(w_lim)) begin
            col_in = '0;
            if (32'(row_cur) + 32'd1 >= 32'(h_lim)) begin
               row_in = '0;
            end else begin
               row_in = row_cur + 1'b1;
            end
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   assign emit_cur = (32'(row_cur) >= 32'd2) && (32'(col_cur) >= 32'd2);
   assign last_cur = (32'(row_cur) == 32'(h_lim) - 32'd1) &&
                     (32'(col_cur) == 32'(w_lim) - 32'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage 1 register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (free1) begin
         s1_v_ff <= in_valid;
      end
      if (accept) begin
         s1_col_ff   <= col_cur;
         s1_row_ff   <= row_cur;
         s1_px_ff    <= in_pixel;
         s1_emit_ff  <= emit_cur;
         s1_last_ff  <= last_cur;
         // upper store entry is being written this cycle by the leaving beat
         s1_byp_ff   <= s1_v_ff && (col_cur == s1_col_ff);
         byp_data_ff <= mid_rd;
      end
   end

   // middle store: written with the new pixel, read old value at the same column
   rgbsharp_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_middle_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_cur),
      .wr_data (in_pixel),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (mid_rd)
   );

   // upper store: takes the middle row entry once it has been read
   rgbsharp_ram #(
      .WIDTH ($bits(pixel_type)),
      .DEPTH (MAX_WIDTH)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (s1_leave),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (top_rd)
   );

   assign top_eff = s1_byp_ff ? byp_data_ff : top_rd;

   // window shift, in beat order
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         up_ff   <= '0;
         cen_ff  <= '0;
         down_ff <= '0;
      end else if (s1_leave) begin
         left_ff <= cen_ff;
         up_ff   <= top_eff;
         cen_ff  <= mid_rd;
         down_ff <= s1_px_ff;
      end
   end

   assign tap_valid    = s1_v_ff && s1_emit_ff;
   assign taps.left    = left_ff;
   assign taps.up      = up_ff;
   assign taps.center  = cen_ff;
   assign taps.down    = down_ff;
   assign taps.right   = mid_rd;
   assign tap_column   = s1_col_ff - 1'b1;
   assign tap_row      = s1_row_ff - 1'b1;
   assign tap_last     = s1_last_ff;

endmodule

`default_nettype wire

// File: rtl/rgbsharp_kernel.sv
// Sharpen arithmetic: Laplacian sum, gain multiply, divide by 100 and clamp.
// Three register stages, the last is the output register. Depends on rgbsharp_pkg.
`default_nettype none

module rgbsharp_kernel
   import rgbsharp_pkg::*;
#(
   parameter int COL_W = 11,
   parameter int ROW_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [6:0]       amount,
   input  logic             in_valid,
   output logic             in_ready,
   input  taps_type         taps,
   input  logic [COL_W-1:0] in_column,
   input  logic [ROW_W-1:0] in_row,
   input  logic             in_last,
   output logic             out_valid,
   input  logic             out_ready,
   output pixel_type        out_pixel,
   output logic [COL_W-1:0] out_column,
   output logic [ROW_W-1:0] out_row,
   output logic             out_last
);

   logic free2, free3, free4;

   logic [7:0]        ch_left[3], ch_up[3], ch_cen[3], ch_down[3], ch_right[3];
   logic [11:0]       sum_in[3];
   logic signed [20:0] prod_in[3];
   logic [27:0]       quot[3];
   logic [7:0]        res_in[3];
   logic [7:0]        s3_cen_ch[3];

   // stage 2: Laplacian sum
   logic               s2_v_ff;
   logic signed [11:0] s2_sum_ff[3];
   pixel_type          s2_cen_ff;
   logic               s2_pass_ff;
   logic [7:0]         s2_k_ff;
   logic [COL_W-1:0]   s2_col_ff;
   logic [ROW_W-1:0]   s2_row_ff;
   logic               s2_last_ff;

   // stage 3: scaled sum
   logic               s3_v_ff;
   logic signed [20:0] s3_prod_ff[3];
   pixel_type          s3_cen_ff;
   logic               s3_pass_ff;
   logic [COL_W-1:0]   s3_col_ff;
   logic [ROW_W-1:0]   s3_row_ff;
   logic               s3_last_ff;

   // stage 4: output register
   logic               s4_v_ff;
   logic [7:0]         s4_res_ff[3];
   logic [COL_W-1:0]   s4_col_ff;
   logic [ROW_W-1:0]   s4_row_ff;
   logic               s4_last_ff;

   assign free4    = !s4_v_ff || out_ready;
   assign free3    = !s3_v_ff || free4;
   assign free2    = !s2_v_ff || free3;
   assign in_ready = free2;

   // split neighbors into channels, red first
   always_comb begin
      ch_left[0]  = taps.left.red;   ch_left[1]  = taps.left.green;
      ch_left[2]  = taps.left.blue;
      ch_up[0]    = taps.up.red;     ch_up[1]    = taps.up.green;
      ch_up[2]    = taps.up.blue;
      ch_cen[0]   = taps.center.red; ch_cen[1]   = taps.center.green;
      ch_cen[2]   = taps.center.blue;
      ch_down[0]  = taps.down.red;   ch_down[1]  = taps.down.green;
      ch_down[2]  = taps.down.blue;
      ch_right[0] = taps.right.red;  ch_right[1] = taps.right.green;
      ch_right[2] = taps.right.blue;
   end

   // 5*center - 4 neighbors, fits 12 bits signed (-1020..1275)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = 12'(ch_cen[i]) * 12'd5 - 12'(ch_up[i]) - 12'(ch_down[i])
                     - 12'(ch_left[i]) - 12'(ch_right[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (free2) begin
         s2_v_ff <= in_valid;
      end
      if (free2) begin
         for (int i = 0; i < 3; i++) begin
            s2_sum_ff[i] <= $signed(sum_in[i]);
         end
         s2_cen_ff  <= taps.center;
         s2_pass_ff <= (amount == PASS_AMOUNT) || (amount > MAX_AMOUNT);
         s2_k_ff    <= 8'(amount) + AMOUNT_BIAS;
         s2_col_ff  <= in_column;
         s2_row_ff  <= in_row;
         s2_last_ff <= in_last;
      end
   end

   // gain multiply
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = s2_sum_ff[i] * $signed({1'b0, s2_k_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (free3) begin
         s3_v_ff <= s2_v_ff;
      end
      if (free3) begin
         for (int i = 0; i < 3; i++) begin
            s3_prod_ff[i] <= prod_in[i];
         end
         s3_cen_ff  <= s2_cen_ff;
         s3_pass_ff <= s2_pass_ff;
         s3_col_ff  <= s2_col_ff;
         s3_row_ff  <= s2_row_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   // divide by 100 through the reciprocal, clamp to 0..255
   always_comb begin
      s3_cen_ch[0] = s3_cen_ff.red;
      s3_cen_ch[1] = s3_cen_ff.green;
      s3_cen_ch[2] = s3_cen_ff.blue;
      for (int i = 0; i < 3; i++) begin
         quot[i] = 28'(s3_prod_ff[i][14:0]) * 28'(RECIP_100);
         if (s3_pass_ff) begin
            res_in[i] = s3_cen_ch[i];
         end else if (s3_prod_ff[i] <= 21'sd0) begin
            res_in[i] = '0;
         end else if (s3_prod_ff[i] >= 21'(CLAMP_LIMIT)) begin
            res_in[i] = PIXEL_MAX;
         end else begin
            res_in[i] = 8'(quot[i] >> RECIP_SHIFT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (free4) begin
         s4_v_ff <= s3_v_ff;
      end
      if (free4) begin
         for (int i = 0; i < 3; i++) begin
            s4_res_ff[i] <= res_in[i];
         end
         s4_col_ff  <= s3_col_ff;
         s4_row_ff  <= s3_row_ff;
         s4_last_ff <= s3_last_ff;
      end
   end

   assign out_valid       = s4_v_ff;
   assign out_pixel.red   = s4_res_ff[0];
   assign out_pixel.green = s4_res_ff[1];
   assign out_pixel.blue  = s4_res_ff[2];
   assign out_column      = s4_col_ff;
   assign out_row         = s4_row_ff;
   assign out_last        = s4_last_ff;

endmodule

`default_nettype wire

// File: rtl/rgbsharp_checker.sv
// Port-level checks for the RGB 3x3 sharpen block, bound to its top level.
// Depends only on the port list of rgb_sharpen_3x3_convolution.
`default_nettype none

module rgbsharp_checker #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [7:0]                    rsp_red_out,
   input logic [7:0]                    rsp_green_out,
   input logic [7:0]                    rsp_blue_out,
   input logic [$clog2(MAX_WIDTH)-1:0]  rsp_out_column,
   input logic [$clog2(MAX_HEIGHT)-1:0] rsp_out_row,
   input logic                          rsp_last_of_frame
);

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   // input only backs up when the output register is full and stalled
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while output side can move");

   // emitted pixels are interior: never column 0 or row 0
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_column != '0 && rsp_out_row != '0))
      else $error("border pixel emitted");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid &&
         $stable({rsp_red_out, rsp_green_out, rsp_blue_out, rsp_out_column,
                  rsp_out_row, rsp_last_of_frame})))
      else $error("stalled result beat changed");

endmodule

bind rgb_sharpen_3x3_convolution rgbsharp_checker #(
   .MAX_WIDTH  (MAX_WIDTH),
   .MAX_HEIGHT (MAX_HEIGHT)
) u_checker (.*);

`default_nettype wire

// File: tb/sv/sharpen_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the RGB 3x3 sharpen block: predicts the sharpened pixel stream
// and checks result beats in order. Depends on rgbsharp_pkg (pixel type, register
// indexes, gain constants).
package sharpen_scoreboard_pkg;
   import rgbsharp_pkg::*;

   localparam int unsigned LINE_MAX   = 2048;
   localparam int unsigned ROWS_MAX   = 4096;
   localparam int          GAIN_SCALE = 100;   // amount is in percent

   typedef struct packed {
      pixel_type   pixel;
      logic [10:0] column;
      logic [11:0] row;
      logic        last;
   } sharp_result_type;

   class sharpen_scoreboard;
      pixel_type        upper_line [LINE_MAX];
      pixel_type        middle_line [LINE_MAX];
      // [0..2] top/mid/bottom of column c-2, [3..5] the same for column c-1
      pixel_type        window [6];
      int unsigned      col_pos;
      int unsigned      row_pos;
      logic [6:0]       amount;
      logic [11:0]      width_reg;
      logic [12:0]      height_reg;
      sharp_result_type predicted_pixels [$];
      int unsigned      errors;
      int unsigned      pixels_in;
      int unsigned      results_checked;
      int unsigned      frames_closed;

      function new();
         foreach (upper_line[i]) begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
         end
         foreach (window[i]) window[i] = '0;
         col_pos         = 0;
         row_pos         = 0;
         amount          = AMOUNT_RESET;
         width_reg       = WIDTH_RESET;
         height_reg      = HEIGHT_RESET;
         errors          = 0;
         pixels_in       = 0;
         results_checked = 0;
         frames_closed   = 0;
      endfunction

      // Dimension as the block uses it: at least 3, at most the store size
      static function int unsigned usable_dim(int unsigned v, int unsigned top);
         if (v < 3) return 3;
         if (v > top) return top;
         return v;
      endfunction

      static function logic [7:0] sharpen_channel(logic [7:0] cen, logic [7:0] up,
                                                  logic [7:0] down, logic [7:0] left,
                                                  logic [7:0] right, int gain);
         int lap;
         int prod;
         lap  = 5 * int'(cen) - int'(up) - int'(down) - int'(left) - int'(right);
         prod = lap * gain;
         // one truncation at the very end, then clamp
         if (prod <= 0) return 8'd0;
         if (prod / GAIN_SCALE > int'(PIXEL_MAX)) return PIXEL_MAX;
         return 8'(prod / GAIN_SCALE);
      endfunction

      function void write_register(reg_index_type idx, logic [31:0] data);
         case (idx)
            REG_AMOUNT: amount     = data[6:0];
            REG_WIDTH:  width_reg  = data[11:0];
            REG_HEIGHT: height_reg = data[12:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending_count();
         return predicted_pixels.size();
      endfunction

      // Accepted input beat: advance the window and queue any result it completes
      function void note_pixel(pixel_type px, logic frame_start);
         int unsigned      w;
         int unsigned      h;
         int               gain;
         bit               pass;
         pixel_type        top;
         pixel_type        mid;
         pixel_type        left;
         pixel_type        up;
         pixel_type        cen;
         pixel_type        down;
         sharp_result_type due;

         w = usable_dim(width_reg, LINE_MAX);
         h = usable_dim(height_reg, ROWS_MAX);
         pixels_in++;

         if (frame_start) begin
            col_pos = 0;
            row_pos = 0;
         end
         if (col_pos >= w) col_pos = 0;
         if (row_pos >= h) row_pos = 0;

         top = upper_line[col_pos];
         mid = middle_line[col_pos];

         // window center sits one row up and one column left of this pixel
         if (row_pos >= 2 && col_pos >= 2) begin
            left = window[1];
            up   = window[3];
            cen  = window[4];
            down = window[5];
            pass = (amount == PASS_AMOUNT) || (amount > MAX_AMOUNT);
            gain = int'(amount) + int'(AMOUNT_BIAS);
            if (pass) begin
               due.pixel = cen;
            end else begin
               due.pixel.red   = sharpen_channel(cen.red, up.red, down.red,
                                                 left.red, mid.red, gain);
               due.pixel.green = sharpen_channel(cen.green, up.green, down.green,
                                                 left.green, mid.green, gain);
               due.pixel.blue  = sharpen_channel(cen.blue, up.blue, down.blue,
                                                 left.blue, mid.blue, gain);
            end
            due.column = 11'(col_pos - 1);
            due.row    = 12'(row_pos - 1);
            due.last   = (row_pos == h - 1) && (col_pos == w - 1);
            predicted_pixels.push_back(due);
         end

         window[0] = window[3];
         window[1] = window[4];
         window[2] = window[5];
         window[3] = top;
         window[4] = mid;
         window[5] = px;

         upper_line[col_pos]  = mid;
         middle_line[col_pos] = px;

         // raster advance, wrapping at the end of the image
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
         end
      endfunction

      // Accepted result beat: compare with the oldest prediction
      function void check_result(sharp_result_type got);
         sharp_result_type due;
         if (predicted_pixels.size() == 0) begin
            $error("result beat at row %0d column %0d with nothing expected",
                   got.row, got.column);
            errors++;
            return;
         end
         due = predicted_pixels.pop_front();
         results_checked++;
         if (got.last === 1'b1) frames_closed++;
         if (got.pixel.red !== due.pixel.red) begin
            $error("red_out: expected %0d, got %0d", due.pixel.red, got.pixel.red);
            errors++;
         end
         if (got.pixel.green !== due.pixel.green) begin
            $error("green_out: expected %0d, got %0d", due.pixel.green, got.pixel.green);
            errors++;
         end
         if (got.pixel.blue !== due.pixel.blue) begin
            $error("blue_out: expected %0d, got %0d", due.pixel.blue, got.pixel.blue);
            errors++;
         end
         if (got.column !== due.column) begin
            $error("out_column: expected %0d, got %0d", due.column, got.column);
            errors++;
         end
         if (got.row !== due.row) begin
            $error("out_row: expected %0d, got %0d", due.row, got.row);
            errors++;
         end
         if (got.last !== due.last) begin
            $error("last_of_frame: expected %0d, got %0d", due.last, got.last);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for rgb_sharpen_3x3_convolution: streams pixel images with
// random gaps and stalls, programs the APB registers between phases and checks
// every result beat. Depends on rgbsharp_pkg, sharpen_scoreboard_pkg and the RTL.
module tb_top;
   import rgbsharp_pkg::*;
   import sharpen_scoreboard_pkg::*;

   localparam int unsigned DRAIN_CYCLES   = 16;    // pipeline is about 4 deep
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned LONG_HOLD      = 400;
   localparam int unsigned RANDOM_PIXELS  = 650;

   typedef enum int unsigned {
      TEXTURE_NOISE,
      TEXTURE_BINARY,
      TEXTURE_SOFT
   } texture_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_red_in = '0;
   logic [7:0]  req_green_in = '0;
   logic [7:0]  req_blue_in = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [10:0] rsp_out_column;
   logic [11:0] rsp_out_row;
   logic        rsp_last_of_frame;

   sharpen_scoreboard sb = new();
   bit                src_idles;
   bit                sink_idles;
   bit                long_hold_req;
   int unsigned       quiet_cycles;
   int unsigned       config_writes;

   rgb_sharpen_3x3_convolution #(
      .MAX_WIDTH  (LINE_MAX),
      .MAX_HEIGHT (ROWS_MAX)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_red_in        (req_red_in),
      .req_green_in      (req_green_in),
      .req_blue_in       (req_blue_in),
      .req_frame_start   (req_frame_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red_out       (rsp_red_out),
      .rsp_green_out     (rsp_green_out),
      .rsp_blue_out      (rsp_blue_out),
      .rsp_out_column    (rsp_out_column),
      .rsp_out_row       (rsp_out_row),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] shade(texture_type tex);
      case (tex)
         TEXTURE_NOISE:  return 8'($urandom);
         TEXTURE_BINARY: return ($urandom_range(0, 1) != 0) ? PIXEL_MAX : 8'd0;
         default:        return 8'($urandom_range(96, 160));
      endcase
   endfunction

   // Beat monitor, scoreboard hookup and watchdog
   always @(posedge clock) begin
      sharp_result_type got;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (req_valid && req_ready) begin
            sb.note_pixel({req_red_in, req_green_in, req_blue_in}, req_frame_start);
            quiet_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            got.pixel  = {rsp_red_out, rsp_green_out, rsp_blue_out};
            got.column = rsp_out_column;
            got.row    = rsp_out_row;
            got.last   = rsp_last_of_frame;
            sb.check_result(got);
            quiet_cycles = 0;
         end
         if (psel && penable && pwrite && pready) begin
            sb.write_register(reg_index_type'(paddr[3:2]), pwdata);
            config_writes++;
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Result side: random stalls, plus one long hold on request
   initial begin : result_sink
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left    = LONG_HOLD;
         end else if (stall_left == 0 && sink_idles && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // One pixel beat; entered and left at a falling edge, valid left high
   task automatic send_pixel(pixel_type px, logic first);
      int unsigned gap;
      gap = 0;
      if (src_idles && $urandom_range(0, 3) == 0) gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_red_in      <= px.red;
      req_green_in    <= px.green;
      req_blue_in     <= px.blue;
      req_frame_start <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame(int unsigned count, texture_type tex, logic restart,
                             int unsigned hold_at);
      for (int unsigned i = 0; i < count; i++) begin
         if (hold_at != 0 && i == hold_at) long_hold_req = 1'b1;
         send_pixel({shade(tex), shade(tex), shade(tex)}, restart && i == 0);
      end
   endtask

   // APB write followed by a read-back of the same register
   task automatic apb_write(reg_index_type idx, logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] readback;
      case (idx)
         REG_AMOUNT: mask = 32'h7F;
         REG_WIDTH:  mask = 32'hFFF;
         REG_HEIGHT: mask = 32'h1FFF;
         default:    mask = '1;
      endcase
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== (value & mask)) begin
         $error("register %s read back: expected %0d, got %0d", idx.name(),
                value & mask, readback);
         sb.errors++;
      end
   endtask

   // Let the block go idle, then program all three registers
   task automatic configure(logic [6:0] gain_pct, logic [11:0] cols, logic [12:0] rows);
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      apb_write(REG_AMOUNT, 32'(gain_pct));
      apb_write(REG_WIDTH, 32'(cols));
      apb_write(REG_HEIGHT, 32'(rows));
   endtask

   initial begin : stimulus
      int unsigned w;
      int unsigned h;
      int unsigned frames;
      int unsigned cut;
      int unsigned random_pixels;
      logic [6:0]  gain_pct;
      logic [11:0] cols;
      logic [12:0] rows;
      bit          restart;
      texture_type tex;

      src_idles  = 1'b0;
      sink_idles = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Bright center on black at full strength: clamps high
      configure(MAX_AMOUNT, 12'd3, 13'd3);
      for (int i = 0; i < 9; i++) begin
         send_pixel((i == 4) ? 24'hFF_FF_FF : 24'h00_00_00, i == 0);
      end
      // Weakest gain, counters wrap into a new image without a frame start;
      // blue goes negative and clamps to zero
      configure(7'd0, 12'd3, 13'd3);
      for (int i = 0; i < 9; i++) begin
         send_pixel((i == 4) ? 24'hC8_80_11 : 24'h30_00_FF, 1'b0);
      end
      // Start of an image left unfinished; the next phase restarts mid-image
      send_frame(4, TEXTURE_NOISE, 1'b0, 0);

      // Width beyond the line store acts as full width: the first row stays silent
      src_idles  = 1'b1;
      sink_idles = 1'b1;
      configure(7'd85, 12'hFFF, 13'd3);
      send_frame(256, TEXTURE_SOFT, 1'b1, 0);

      // Mid-size image with a long output hold in row 4
      configure(7'd85, 12'd32, 13'd8);
      send_frame(32 * 8, TEXTURE_SOFT, 1'b1, 32 * 4 + 10);

      // Height beyond the row limit; only the top of the image is sent
      configure(MAX_AMOUNT, 12'd3, 13'h1FFF);
      send_frame(3 * 40, TEXTURE_NOISE, 1'b1, 0);

      // Random phases: small images, varied strength, some cut short
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         case ($urandom_range(0, 5))
            0:       gain_pct = 7'd0;
            1:       gain_pct = PASS_AMOUNT;
            2:       gain_pct = MAX_AMOUNT;
            3:       gain_pct = 7'($urandom_range(101, 127));
            default: gain_pct = 7'($urandom_range(0, 127));
         endcase
         cols = ($urandom_range(0, 5) == 0) ? 12'($urandom_range(0, 2))
                                           : 12'($urandom_range(3, 16));
         rows = ($urandom_range(0, 5) == 0) ? 13'($urandom_range(0, 2))
                                           : 13'($urandom_range(3, 8));
         configure(gain_pct, cols, rows);
         src_idles  = ($urandom_range(0, 3) != 0);
         sink_idles = ($urandom_range(0, 3) != 0);
         w = sharpen_scoreboard::usable_dim(cols, LINE_MAX);
         h = sharpen_scoreboard::usable_dim(rows, ROWS_MAX);
         frames  = $urandom_range(1, 4);
         restart = 1'b1;
         for (int unsigned f = 0; f < frames; f++) begin
            tex = texture_type'($urandom_range(0, 2));
            if ($urandom_range(0, 7) == 0) begin
               // broken image, the following one restarts mid-image
               cut = $urandom_range(1, w * h - 1);
               send_frame(cut, tex, restart, 0);
               random_pixels += cut;
               restart = 1'b1;
            end
            send_frame(w * h, tex, restart, 0);
            random_pixels += w * h;
            restart = ($urandom_range(0, 1) != 0);
         end
      end

      // Drain and report
      req_valid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("sent %0d pixels, checked %0d sharpened pixels over %0d completed images",
               sb.pixels_in, sb.results_checked, sb.frames_closed);
      $display("%0d register writes covering pass-through, gain and size limits",
               config_writes);
      if (sb.errors == 0 && sb.pending_count() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/rgbsharp_pkg.sv
rtl/rgbsharp_ram.sv
rtl/rgbsharp_window.sv
rtl/rgbsharp_kernel.sv
rtl/rgb_sharpen_3x3_convolution.sv
rtl/rgbsharp_checker.sv
tb/sv/sharpen_scoreboard_pkg.sv
tb/sv/tb_top.sv
